FILE: src/tbpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpr_pkg
// Shared types and constants for the background tile pixel renderer.
// ----------------------------------------------------------------------------
package tbpr_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 240;

  localparam int VMEM_DEPTH = 16384;
  localparam int VMEM_AW    = 14;
  localparam int VMEM_DW    = 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NAMETABLE_SELECT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND_SELECT = 1'd1;

  // item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  // fixed address fields
  localparam logic [1:0] NT_ORIGIN_TOP = 2'b10;    // 0x2000
  localparam logic [3:0] ATTR_ROW      = 4'b1111;  // 0x3c0 within a nametable
  localparam logic [9:0] PAL_PAGE      = 10'h3f0;  // 0x3f00 >> 4
  localparam logic [5:0] COLOR_MASK    = 6'h3f;

  typedef struct packed {
    logic               we;
    logic [VMEM_AW-1:0] addr;
    logic [VMEM_DW-1:0] wdata;
  } mem_req_t;

endpackage

FILE: src/tbpr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpr_ram
// Generic single-port RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module tbpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/tbpr_fetch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpr_fetch
// Fetch sequencer: issues nametable/attribute, pattern lo/hi and palette
// reads over the two memory copies, and mirrors writes into both.
// ----------------------------------------------------------------------------
module tbpr_fetch (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      mode,
  input  logic [13:0]               mem_address,
  input  logic [7:0]                mem_data,
  input  logic [7:0]                pixel_x,
  input  logic [7:0]                pixel_y,
  input  logic [1:0]                nametable_select,
  input  logic                      background_table_select,
  input  logic [7:0]                rdata_a,
  input  logic [7:0]                rdata_b,
  output logic                      busy,
  output logic                      pal_pending,
  output tbpr_pkg::mem_req_t        req_a,
  output tbpr_pkg::mem_req_t        req_b
);

  import tbpr_pkg::*;

  logic       accept;
  logic       render_go;
  logic       write_go;

  // stage 1: nametable and attribute reads in flight
  logic       v1;
  logic [2:0] s1_fx;
  logic [2:0] s1_fy;
  logic [1:0] s1_quad;
  // stage 2: pattern reads in flight
  logic       v2;
  logic [2:0] s2_fx;
  logic [1:0] s2_group;
  // stage 3: palette read in flight
  logic       v3;

  logic [1:0]          group_sel;
  logic [1:0]          pix_value;
  logic [2:0]          bit_sel;
  logic [VMEM_AW-1:0]  nt_addr;
  logic [VMEM_AW-1:0]  attr_addr;
  logic [VMEM_AW-1:0]  pat_lo_addr;
  logic [VMEM_AW-1:0]  pat_hi_addr;
  logic [VMEM_AW-1:0]  pal_addr;

  assign busy        = v1 | v2;
  assign pal_pending = v3;
  assign accept      = start & ~busy;
  assign render_go   = accept & (mode == MODE_RENDER);
  assign write_go    = accept & (mode == MODE_WRITE);

  assign nt_addr   = {NT_ORIGIN_TOP, nametable_select, pixel_y[7:3], pixel_x[7:3]};
  assign attr_addr = {NT_ORIGIN_TOP, nametable_select, ATTR_ROW, pixel_y[7:5], pixel_x[7:5]};

  assign pat_lo_addr = {1'b0, background_table_select, rdata_a, 1'b0, s1_fy};
  assign pat_hi_addr = {1'b0, background_table_select, rdata_a, 1'b1, s1_fy};

  assign group_sel = rdata_b[{s1_quad, 1'b0} +: 2];

  assign bit_sel   = ~s2_fx;  // 7 - fine x
  assign pix_value = {rdata_b[bit_sel], rdata_a[bit_sel]};
  assign pal_addr  = (pix_value == 2'd0) ? {PAL_PAGE, 4'd0}
                                         : {PAL_PAGE, s2_group, pix_value};

  always_comb begin
    req_a = '0;
    req_b = '0;
    if (write_go) begin
      req_a.we    = 1'b1;
      req_a.addr  = mem_address;
      req_a.wdata = mem_data;
      req_b.we    = 1'b1;
      req_b.addr  = mem_address;
      req_b.wdata = mem_data;
    end else if (render_go) begin
      req_a.addr = nt_addr;
      req_b.addr = attr_addr;
    end else if (v1) begin
      req_a.addr = pat_lo_addr;
      req_b.addr = pat_hi_addr;
    end else if (v2) begin
      req_a.addr = pal_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= render_go;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (render_go) begin
      s1_fx   <= pixel_x[2:0];
      s1_fy   <= pixel_y[2:0];
      s1_quad <= {pixel_y[4], pixel_x[4]};
    end
    if (v1) begin
      s2_fx    <= s1_fx;
      s2_group <= group_sel;
    end
  end

`ifndef NO_ASSERTIONS
  a_stage_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({v1, v2, v3}))
    else $error("more than one render stage active");

  a_render_enters: assert property (@(posedge clk) disable iff (rst)
    render_go |=> v1 && !v2)
    else $error("accepted render did not enter stage 1");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    v1 |=> v2 && !v1)
    else $error("stage 1 did not advance");

  a_write_mirrored: assert property (@(posedge clk) disable iff (rst)
    (req_a.we || req_b.we) |-> (req_a.we && req_b.we && req_a.addr == req_b.addr
                                && req_a.wdata == req_b.wdata))
    else $error("memory copies written differently");

  a_no_write_in_flight: assert property (@(posedge clk) disable iff (rst)
    (v1 || v2) |-> !req_a.we)
    else $error("write issued while render reads in flight");
`endif

endmodule

FILE: src/tile_background_pixel_render.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_pixel_render
// Background tile pixel renderer over a 16K-byte video memory held as two
// mirrored single-port copies.
// ----------------------------------------------------------------------------
// A render result strobes on color_valid, registered from the palette read,
//   the last of three dependent read rounds after tile/attribute and pattern.
// A write per cycle while not busy; a render can overlap only a palette round.
// Reset clears the configuration registers and the fetch pipeline; video
//   memory holds no defined value until written. Results cannot be stalled.
module tile_background_pixel_render (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 mode,
  input  logic [13:0]                          mem_address,
  input  logic [7:0]                           mem_data,
  input  logic [7:0]                           pixel_x,
  input  logic [7:0]                           pixel_y,
  input  logic                                 cfg_write,
  input  logic [tbpr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tbpr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 color_valid,
  output logic [5:0]                           color_index
);

  import tbpr_pkg::*;

  logic [1:0] nametable_select;
  logic       background_table_select;
  logic       pal_pending;
  mem_req_t   req_a;
  mem_req_t   req_b;
  logic [7:0] rdata_a;
  logic [7:0] rdata_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      nametable_select        <= 2'd0;
      background_table_select <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NAMETABLE_SELECT:  nametable_select        <= cfg_data[1:0];
        CFG_BACKGROUND_SELECT: background_table_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tbpr_fetch u_fetch (
    .clk                     (clk),
    .rst                     (rst),
    .start                   (start),
    .mode                    (mode),
    .mem_address             (mem_address),
    .mem_data                (mem_data),
    .pixel_x                 (pixel_x),
    .pixel_y                 (pixel_y),
    .nametable_select        (nametable_select),
    .background_table_select (background_table_select),
    .rdata_a                 (rdata_a),
    .rdata_b                 (rdata_b),
    .busy                    (busy),
    .pal_pending             (pal_pending),
    .req_a                   (req_a),
    .req_b                   (req_b)
  );

  tbpr_ram #(
    .WIDTH (VMEM_DW),
    .DEPTH (VMEM_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (req_a.we),
    .addr  (req_a.addr),
    .wdata (req_a.wdata),
    .rdata (rdata_a)
  );

  tbpr_ram #(
    .WIDTH (VMEM_DW),
    .DEPTH (VMEM_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (req_b.we),
    .addr  (req_b.addr),
    .wdata (req_b.wdata),
    .rdata (rdata_b)
  );

  // palette byte lands while the pipeline sits in its last stage
  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else begin
      color_valid <= pal_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_pending) begin
      color_index <= rdata_a[5:0] & COLOR_MASK;
    end
  end

endmodule
